### rtl/mouse_packet_decoder_top_macros.svh
// Assertion macros used by the mouse packet decoder checker.
`ifndef MOUSE_PACKET_DECODER_TOP_MACROS_SVH
`define MOUSE_PACKET_DECODER_TOP_MACROS_SVH

// Check a property on every clock edge outside reset.
`define MPD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MPD_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/mpd_pkg.sv
// Types and constants for the mouse packet decoder.
`default_nettype none

package mpd_pkg;

    localparam int POS_BITS = 12;
    localparam int REG_W    = 12;
    localparam int BYTE_W   = 8;
    localparam int BTN_W    = 3;
    localparam int IDX_W    = 8;
    localparam int SUM_W    = POS_BITS + 2;
    localparam int LIM_W    = (POS_BITS > REG_W) ? POS_BITS : REG_W;
    localparam int OUT_W    = ((BTN_W + 2 * REG_W + 7) / 8) * 8;

    // Bit positions in the packet header byte
    localparam int SYNC_BIT  = 3;
    localparam int XSIGN_BIT = 4;
    localparam int YSIGN_BIT = 5;

    // Frame position codes
    localparam logic [1:0] FR_HEAD = 2'd0;
    localparam logic [1:0] FR_DX   = 2'd1;
    localparam logic [1:0] FR_DY   = 2'd2;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] REG_MAX_X = IDX_W'(0);
    localparam logic [IDX_W-1:0] REG_MAX_Y = IDX_W'(1);

    localparam logic [REG_W-1:0] MAX_X_RESET = REG_W'(1023);
    localparam logic [REG_W-1:0] MAX_Y_RESET = REG_W'(767);

    typedef logic [POS_BITS-1:0]     pos_t;
    typedef logic [REG_W-1:0]        reg_t;
    typedef logic [LIM_W-1:0]        lim_t;
    typedef logic signed [SUM_W-1:0] sum_t;
    typedef logic [BYTE_W-1:0]       byte_t;
    typedef logic [BTN_W-1:0]        btn_t;

    localparam pos_t POS_MAX = '1;

    // One axis move request: old position, 9-bit signed delta and limit
    typedef struct packed {
        pos_t  pos;
        logic  sign;
        byte_t low;
        reg_t  limit;
    } move_req_t;

endpackage

`default_nettype wire

### rtl/mpd_axis_clamp.sv
// Adds a signed delta to one axis position and clamps it to 0..limit.
`default_nettype none

module mpd_axis_clamp (
    input  wire mpd_pkg::move_req_t req,
    output mpd_pkg::pos_t           pos_next
);

    logic signed [mpd_pkg::BYTE_W:0] delta9;
    mpd_pkg::sum_t                   sum;
    mpd_pkg::lim_t                   lim_wide;
    mpd_pkg::pos_t                   lim;

    always_comb
    begin
        delta9   = {req.sign, req.low};
        sum      = mpd_pkg::sum_t'({2'b00, req.pos}) + mpd_pkg::sum_t'(delta9);
        lim_wide = mpd_pkg::lim_t'(req.limit);
        // saturate the limit to what the position can hold
        if (lim_wide > mpd_pkg::lim_t'(mpd_pkg::POS_MAX))
        begin
            lim = mpd_pkg::POS_MAX;
        end
        else
        begin
            lim = mpd_pkg::pos_t'(lim_wide);
        end
        if (sum[mpd_pkg::SUM_W-1])
        begin
            pos_next = '0;
        end
        else if (sum > mpd_pkg::sum_t'({2'b00, lim}))
        begin
            pos_next = lim;
        end
        else
        begin
            pos_next = mpd_pkg::pos_t'(sum);
        end
    end

endmodule

`default_nettype wire

### rtl/mouse_packet_decoder_top.sv
// Top level of the mouse packet decoder: framing, position update and ports.
// Output: a result appears on m_axis in the cycle after the third byte of a packet is taken.
// Throughput: one byte per cycle; s_axis_tready drops only when a third byte
//   meets a result still held in the output register.
// Reset (rst_n, asynchronous, active low): frame back to the header byte, position 0,0,
//   limits 1023 and 767, output register empty.
`default_nettype none

module mouse_packet_decoder_top (
    input  wire                          clk,
    input  wire                          rst_n,
    // input bytes
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [mpd_pkg::BYTE_W-1:0]   s_axis_tdata,  // [7:0] rx_byte
    // packet results
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [mpd_pkg::OUT_W-1:0]    m_axis_tdata,  // [2:0] buttons, [14:3] pos_x,
                                                        // [26:15] pos_y, rest zero
    // register writes
    input  wire                          cfg_valid,
    output logic                         cfg_ready,
    input  wire  [mpd_pkg::IDX_W-1:0]    cfg_index,
    input  wire  [mpd_pkg::REG_W-1:0]    cfg_data
);

    logic [1:0]            frame_reg, frame_next;
    mpd_pkg::btn_t         btn_reg, btn_next;
    logic                  sign_x_reg, sign_x_next;
    logic                  sign_y_reg, sign_y_next;
    mpd_pkg::byte_t        dx_reg, dx_next;
    mpd_pkg::pos_t         abs_x_reg, abs_x_next;
    mpd_pkg::pos_t         abs_y_reg, abs_y_next;
    mpd_pkg::reg_t         max_x_reg, max_y_reg;
    logic                  out_valid_reg, out_valid_next;
    mpd_pkg::btn_t         out_btn_reg;
    mpd_pkg::reg_t         out_x_reg, out_y_reg;

    mpd_pkg::move_req_t    req_x, req_y;
    mpd_pkg::pos_t         new_x, new_y;
    logic                  in_acc;
    logic                  out_acc;
    logic                  pkt_done;

    // Only the last byte of a packet needs room in the output register;
    // header and X bytes are always taken.
    assign s_axis_tready = (frame_reg != mpd_pkg::FR_DY) || !out_valid_reg || m_axis_tready;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign out_acc       = m_axis_tvalid && m_axis_tready;
    assign pkt_done      = in_acc && (frame_reg == mpd_pkg::FR_DY);
    assign cfg_ready     = 1'b1;

    // Axis move requests: X delta comes from the held byte, Y straight off the bus
    assign req_x = '{pos: abs_x_reg, sign: sign_x_reg, low: dx_reg, limit: max_x_reg};
    assign req_y = '{pos: abs_y_reg, sign: sign_y_reg, low: s_axis_tdata, limit: max_y_reg};

    mpd_axis_clamp u_clamp_x (
        .req      (req_x),
        .pos_next (new_x)
    );

    mpd_axis_clamp u_clamp_y (
        .req      (req_y),
        .pos_next (new_y)
    );

    // Frame sequencing
    always_comb
    begin
        frame_next  = frame_reg;
        btn_next    = btn_reg;
        sign_x_next = sign_x_reg;
        sign_y_next = sign_y_reg;
        dx_next     = dx_reg;
        abs_x_next  = abs_x_reg;
        abs_y_next  = abs_y_reg;
        if (in_acc)
        begin
            unique case (frame_reg)
                mpd_pkg::FR_DX:
                begin
                    dx_next    = s_axis_tdata;
                    frame_next = mpd_pkg::FR_DY;
                end
                mpd_pkg::FR_DY:
                begin
                    abs_x_next = new_x;
                    abs_y_next = new_y;
                    frame_next = mpd_pkg::FR_HEAD;
                end
                default:
                begin
                    // header slot: drop a byte without the sync bit and stay put
                    if (s_axis_tdata[mpd_pkg::SYNC_BIT])
                    begin
                        btn_next    = s_axis_tdata[mpd_pkg::BTN_W-1:0];
                        sign_x_next = s_axis_tdata[mpd_pkg::XSIGN_BIT];
                        sign_y_next = s_axis_tdata[mpd_pkg::YSIGN_BIT];
                        frame_next  = mpd_pkg::FR_DX;
                    end
                    else
                    begin
                        frame_next = mpd_pkg::FR_HEAD;
                    end
                end
            endcase
        end
    end

    // Output register: load on a finished packet, clear once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pkt_done)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_acc)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg     <= mpd_pkg::FR_HEAD;
            btn_reg       <= '0;
            sign_x_reg    <= 1'b0;
            sign_y_reg    <= 1'b0;
            dx_reg        <= '0;
            abs_x_reg     <= '0;
            abs_y_reg     <= '0;
            max_x_reg     <= mpd_pkg::MAX_X_RESET;
            max_y_reg     <= mpd_pkg::MAX_Y_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            frame_reg     <= frame_next;
            btn_reg       <= btn_next;
            sign_x_reg    <= sign_x_next;
            sign_y_reg    <= sign_y_next;
            dx_reg        <= dx_next;
            abs_x_reg     <= abs_x_next;
            abs_y_reg     <= abs_y_next;
            out_valid_reg <= out_valid_next;
            // register writes; an unknown index is dropped
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    mpd_pkg::REG_MAX_X: max_x_reg <= cfg_data;
                    mpd_pkg::REG_MAX_Y: max_y_reg <= cfg_data;
                    default:            ;
                endcase
            end
        end
    end

    // Result payload needs no reset: it is only seen with out_valid_reg set
    always_ff @(posedge clk)
    begin
        if (pkt_done)
        begin
            out_btn_reg <= btn_reg;
            out_x_reg   <= mpd_pkg::reg_t'(new_x);
            out_y_reg   <= mpd_pkg::reg_t'(new_y);
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = mpd_pkg::OUT_W'({out_y_reg, out_x_reg, out_btn_reg});

endmodule

`default_nettype wire

### rtl/mpd_checker.sv
// Port-level checker for the mouse packet decoder, bound to the top level.
`default_nettype none

`include "mouse_packet_decoder_top_macros.svh"

module mpd_checker (
    input wire                        clk,
    input wire                        rst_n,
    input wire                        s_axis_tvalid,
    input wire                        s_axis_tready,
    input wire [mpd_pkg::BYTE_W-1:0]  s_axis_tdata,
    input wire                        m_axis_tvalid,
    input wire                        m_axis_tready,
    input wire [mpd_pkg::OUT_W-1:0]   m_axis_tdata
);

    logic [1:0]     frame_reg;
    mpd_pkg::btn_t  hdr_btn_reg;
    mpd_pkg::btn_t  out_btn;
    logic           in_acc;
    logic           last_acc;
    logic           out_stall;

    assign in_acc    = s_axis_tvalid && s_axis_tready;
    assign last_acc  = in_acc && (frame_reg == mpd_pkg::FR_DY);
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_btn   = m_axis_tdata[mpd_pkg::BTN_W-1:0];

    // Shadow the packet framing from the input side
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_reg   <= mpd_pkg::FR_HEAD;
            hdr_btn_reg <= '0;
        end
        else if (in_acc)
        begin
            unique case (frame_reg)
                mpd_pkg::FR_DX:   frame_reg <= mpd_pkg::FR_DY;
                mpd_pkg::FR_DY:   frame_reg <= mpd_pkg::FR_HEAD;
                default:
                begin
                    if (s_axis_tdata[mpd_pkg::SYNC_BIT])
                    begin
                        frame_reg   <= mpd_pkg::FR_DX;
                        hdr_btn_reg <= s_axis_tdata[mpd_pkg::BTN_W-1:0];
                    end
                end
            endcase
        end
    end

    `MPD_ASSERT(a_stall_hold, out_stall |=> m_axis_tvalid && $stable(m_axis_tdata), "stall broken")
    `MPD_ASSERT(a_result_follows, last_acc |=> m_axis_tvalid, "third byte gave no result")
    `MPD_ASSERT(a_no_spurious, $rose(m_axis_tvalid) |-> $past(last_acc), "orphan result")
    `MPD_ASSERT(a_buttons, last_acc |=> out_btn == $past(hdr_btn_reg), "wrong buttons")

endmodule

bind mouse_packet_decoder_top mpd_checker u_mpd_checker (.*);

`default_nettype wire
